[rtl/core/jtt_pkg.sv]
// Shared types and constants of the job timer table.
`default_nettype none
package jtt_pkg;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] KIND_ADD_ACK = 2'd0;
    localparam logic [1:0] KIND_RM_ACK  = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_IVAL  = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    localparam int          RES_MAX   = 16;
    localparam int          NFIRE_W   = 5;
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam logic [31:0] FIRES_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [51:0] now_us;
        logic        job_kind;
        logic [19:0] period_s;
        logic [31:0] at_epoch_s;
        logic [31:0] remove_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [31:0] entry_id;
        logic [3:0]  slot;
        logic [31:0] fires;
        logic        was_one_shot;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] tag;
        logic        one_shot;
        logic        expired;
        logic [19:0] period;
        logic [52:0] deadline;
        logic [31:0] fires;
    } t_entry;

    typedef struct packed {
        logic take_req;
        logic inc_idx;
        logic rd_next;
        logic mul_req;
        logic mul_ent;
        logic latch_ent;
        logic wr_add;
        logic wr_tick;
        logic wr_shift;
        logic mark_found;
        logic rm_done;
        logic rm_miss;
        logic add_full;
        logic add_bad;
        logic push_fire;
        logic push_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       count_zero;
        logic       count_full;
        logic       bad_interval;
        logic       idx_last;
        logic       idx_next_last;
        logic       tag_match;
        logic       entry_due;
        logic       nfire_last;
        logic       pend_valid;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/core/jtt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/core/jtt_dp.sv]
// Datapath of the job timer table: request latch, entry memory, counters, results.
`default_nettype none
module jtt_dp #(
    parameter int MAX_JOBS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jtt_pkg::t_req i_req,
    input  wire jtt_pkg::t_cmd i_cmd,
    output jtt_pkg::t_sts      o_sts,
    input  wire logic          i_res_ready,
    output logic               o_res_valid,
    output jtt_pkg::t_res      o_res
);

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);

    jtt_pkg::t_req   r_req;
    jtt_pkg::t_entry r_ent;
    jtt_pkg::t_entry rd_ent;
    jtt_pkg::t_entry wr_ent;
    jtt_pkg::t_res   r_pend;
    jtt_pkg::t_res   n_pend;
    jtt_pkg::t_res   r_out;
    jtt_pkg::t_res   n_out;
    jtt_pkg::t_res   fire_res;
    logic            r_pend_v;
    logic            r_out_v;
    logic [CW-1:0]   r_count;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_found;
    logic [jtt_pkg::NFIRE_W-1:0] r_nfire;
    logic [51:0]     r_prod;
    logic [51:0]     n_prod;
    logic [31:0]     mul_op;
    logic [52:0]     base;
    logic [52:0]     new_deadline;
    logic [31:0]     new_fires;
    logic [CW:0]     idx_ext;
    logic [CW:0]     count_ext;
    logic            we;
    logic [IW-1:0]   waddr;
    logic [IW-1:0]   raddr;
    logic            out_free;

    jtt_ram #(
        .WIDTH ($bits(jtt_pkg::t_entry)),
        .DEPTH (MAX_JOBS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_ent),
        .i_raddr (raddr),
        .o_rdata (rd_ent)
    );

    assign raddr = i_cmd.rd_next ? IW'(r_idx + 1'b1) : r_idx;
    assign we    = i_cmd.wr_add | i_cmd.wr_tick | i_cmd.wr_shift;
    assign waddr = i_cmd.wr_add ? IW'(r_count) : r_idx;

    assign mul_op = i_cmd.mul_ent ? {12'd0, rd_ent.period}
                  : (r_req.job_kind ? r_req.at_epoch_s : {12'd0, r_req.period_s});
    assign n_prod = 52'(mul_op) * 52'(jtt_pkg::US_PER_S);

    assign base = (r_req.func == jtt_pkg::FUNC_ADD && r_req.job_kind)
                ? 53'd0 : 53'(r_req.now_us);
    assign new_deadline = base + 53'(r_prod);
    assign new_fires = (r_ent.fires == jtt_pkg::FIRES_MAX) ? r_ent.fires
                     : r_ent.fires + 32'd1;

    always_comb begin
        wr_ent = rd_ent;
        if (i_cmd.wr_add) begin
            wr_ent.tag      = r_req.now_us[31:0];
            wr_ent.one_shot = r_req.job_kind;
            wr_ent.expired  = 1'b0;
            wr_ent.period   = r_req.job_kind ? 20'd0 : r_req.period_s;
            wr_ent.deadline = new_deadline;
            wr_ent.fires    = 32'd0;
        end else if (i_cmd.wr_tick) begin
            wr_ent          = r_ent;
            wr_ent.fires    = new_fires;
            if (r_ent.one_shot) begin
                wr_ent.expired = 1'b1;
            end else begin
                wr_ent.deadline = new_deadline;
            end
        end
    end

    always_comb begin
        fire_res              = '0;
        fire_res.kind         = jtt_pkg::KIND_FIRED;
        fire_res.status       = jtt_pkg::STAT_OK;
        fire_res.entry_id     = r_ent.tag;
        fire_res.slot         = 4'(r_idx);
        fire_res.fires        = new_fires;
        fire_res.was_one_shot = r_ent.one_shot;
    end

    always_comb begin
        n_pend = r_pend;
        if (i_cmd.wr_add) begin
            n_pend          = '0;
            n_pend.kind     = jtt_pkg::KIND_ADD_ACK;
            n_pend.status   = jtt_pkg::STAT_OK;
            n_pend.entry_id = r_req.now_us[31:0];
            n_pend.slot     = 4'(r_count);
        end else if (i_cmd.add_full) begin
            n_pend        = '0;
            n_pend.kind   = jtt_pkg::KIND_ADD_ACK;
            n_pend.status = jtt_pkg::STAT_FULL;
        end else if (i_cmd.add_bad) begin
            n_pend        = '0;
            n_pend.kind   = jtt_pkg::KIND_ADD_ACK;
            n_pend.status = jtt_pkg::STAT_BAD_IVAL;
        end else if (i_cmd.rm_done) begin
            n_pend          = '0;
            n_pend.kind     = jtt_pkg::KIND_RM_ACK;
            n_pend.status   = jtt_pkg::STAT_OK;
            n_pend.entry_id = r_req.remove_id;
            n_pend.slot     = 4'(r_found);
        end else if (i_cmd.rm_miss) begin
            n_pend          = '0;
            n_pend.kind     = jtt_pkg::KIND_RM_ACK;
            n_pend.status   = jtt_pkg::STAT_NOT_FOUND;
            n_pend.entry_id = r_req.remove_id;
        end else if (i_cmd.push_fire) begin
            n_pend = fire_res;
        end
        n_out      = r_pend;
        n_out.last = i_cmd.push_last;
    end

    assign out_free  = !r_out_v || i_res_ready;
    assign idx_ext   = (CW + 1)'(r_idx);
    assign count_ext = (CW + 1)'(r_count);

    assign o_sts.func          = r_req.func;
    assign o_sts.count_zero    = (r_count == '0);
    assign o_sts.count_full    = (r_count >= CW'(MAX_JOBS));
    assign o_sts.bad_interval  = !r_req.job_kind && (r_req.period_s == '0);
    assign o_sts.idx_last      = (idx_ext + 1'b1 == count_ext);
    assign o_sts.idx_next_last = (idx_ext + 2'd2 == count_ext);
    assign o_sts.tag_match     = (rd_ent.tag == r_req.remove_id);
    assign o_sts.entry_due     = !rd_ent.expired && ({1'b0, r_req.now_us} >= rd_ent.deadline);
    assign o_sts.nfire_last    = (r_nfire == jtt_pkg::NFIRE_W'(jtt_pkg::RES_MAX - 1));
    assign o_sts.pend_valid    = r_pend_v;
    assign o_sts.out_free      = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_nfire  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.take_req) begin
                r_idx   <= '0;
                r_nfire <= '0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= IW'(r_idx + 1'b1);
            end
            if (i_cmd.wr_add) begin
                r_count  <= CW'(r_count + 1'b1);
                r_pend_v <= 1'b1;
            end
            if (i_cmd.rm_done) begin
                r_count  <= CW'(r_count - 1'b1);
                r_pend_v <= 1'b1;
            end
            if (i_cmd.rm_miss || i_cmd.add_full || i_cmd.add_bad) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.push_fire) begin
                r_nfire  <= jtt_pkg::NFIRE_W'(r_nfire + 1'b1);
                r_pend_v <= 1'b1;
            end
            if (i_cmd.push_last) begin
                r_pend_v <= 1'b0;
            end
            if ((i_cmd.push_fire && r_pend_v) || i_cmd.push_last) begin
                r_out_v <= 1'b1;
            end else if (i_res_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_req <= i_req;
        end
        if (i_cmd.latch_ent) begin
            r_ent <= rd_ent;
        end
        if (i_cmd.mul_req || i_cmd.mul_ent) begin
            r_prod <= n_prod;
        end
        if (i_cmd.mark_found) begin
            r_found <= r_idx;
        end
        r_pend <= n_pend;
        if ((i_cmd.push_fire && r_pend_v) || i_cmd.push_last) begin
            r_out <= n_out;
        end
    end

    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

endmodule
`default_nettype wire

[rtl/core/jtt_ctrl.sv]
// Controller state machine of the job timer table.
`default_nettype none
module jtt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire jtt_pkg::t_sts i_sts,
    output jtt_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISP,
        ST_A_WR,
        ST_T_RD,
        ST_T_EVAL,
        ST_T_WR,
        ST_R_RD,
        ST_R_CMP,
        ST_S_RD,
        ST_S_WR,
        ST_R_END,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_sts.func)
                    jtt_pkg::FUNC_TICK: begin
                        n_state = i_sts.count_zero ? ST_FIN : ST_T_RD;
                    end
                    jtt_pkg::FUNC_ADD: begin
                        if (i_sts.count_full) begin
                            o_cmd.add_full = 1'b1;
                            n_state        = ST_FIN;
                        end else if (i_sts.bad_interval) begin
                            o_cmd.add_bad = 1'b1;
                            n_state       = ST_FIN;
                        end else begin
                            o_cmd.mul_req = 1'b1;
                            n_state       = ST_A_WR;
                        end
                    end
                    jtt_pkg::FUNC_REMOVE: begin
                        if (i_sts.count_zero) begin
                            o_cmd.rm_miss = 1'b1;
                            n_state       = ST_FIN;
                        end else begin
                            n_state = ST_R_RD;
                        end
                    end
                    default: begin
                        n_state = ST_FIN;
                    end
                endcase
            end
            ST_A_WR: begin
                o_cmd.wr_add = 1'b1;
                n_state      = ST_FIN;
            end
            ST_T_RD: begin
                n_state = ST_T_EVAL;
            end
            ST_T_EVAL: begin
                if (i_sts.entry_due) begin
                    o_cmd.latch_ent = 1'b1;
                    o_cmd.mul_ent   = 1'b1;
                    n_state         = ST_T_WR;
                end else if (i_sts.idx_last) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = ST_T_RD;
                end
            end
            ST_T_WR: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.wr_tick   = 1'b1;
                    o_cmd.push_fire = 1'b1;
                    if (i_sts.idx_last || i_sts.nfire_last) begin
                        n_state = ST_FIN;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = ST_T_RD;
                    end
                end
            end
            ST_R_RD: begin
                n_state = ST_R_CMP;
            end
            ST_R_CMP: begin
                if (i_sts.tag_match) begin
                    o_cmd.mark_found = 1'b1;
                    n_state          = i_sts.idx_last ? ST_R_END : ST_S_RD;
                end else if (i_sts.idx_last) begin
                    o_cmd.rm_miss = 1'b1;
                    n_state       = ST_FIN;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = ST_R_RD;
                end
            end
            ST_S_RD: begin
                o_cmd.rd_next = 1'b1;
                n_state       = ST_S_WR;
            end
            ST_S_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                n_state        = i_sts.idx_next_last ? ST_R_END : ST_S_RD;
            end
            ST_R_END: begin
                o_cmd.rm_done = 1'b1;
                n_state       = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.push_last = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/job_timer_table_core.sv]
// Top level of the job timer table: controller plus datapath.
//
// Request channel (i_req_valid / o_req_ready / i_req) carries tick, add and
// remove requests; result channel (o_res_valid / i_res_ready / o_res) returns
// acknowledges and firings, with last set on the final result of a request.
// One request is processed at a time; o_req_ready is high only while idle.
// Add steps: accept, dispatch and multiply, write, deliver to the result register.
// Remove: read and compare per slot searched, read and write per entry shifted down.
// Tick: read and evaluate per slot scanned, plus a write step per firing entry.
// These steps come from the entry memory with one write and one registered read port
// and the one shared 32x20 multiplier: deadline = now + period * 1e6 or epoch * 1e6.
// Each firing is held one step so the last flag can be set when the scan ends.
// A stalled receiver holds the block at the next result push; an idle output
// register lets the next request be taken while a result still waits.
// Reset empties the table (entry count zero); the memory is not cleared.
`default_nettype none
module job_timer_table_core #(
    parameter int MAX_JOBS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire jtt_pkg::t_req i_req,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output jtt_pkg::t_res      o_res
);

    jtt_pkg::t_cmd cmd;
    jtt_pkg::t_sts sts;

    jtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    jtt_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_res_ready (i_res_ready),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

[dv/job_timer_table_core_tb.sv]
// Self-checking testbench for job_timer_table_core: directed and random tick/add/remove traffic.
module job_timer_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         JOBS        = 16;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] tag;
        logic        one_shot;
        logic        expired;
        logic [19:0] period;
        logic [52:0] due_us;
        logic [31:0] fire_cnt;
    } t_timer_slot;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          res_ready = 1'b0;
    jtt_pkg::t_req req       = '0;
    logic          o_req_ready;
    logic          o_res_valid;
    jtt_pkg::t_res o_res;

    t_timer_slot   timer_slots[JOBS];
    int            slot_count;
    jtt_pkg::t_res pending_results[$];
    logic [51:0]   sim_now;
    logic [51:0]   last_add_now;
    bit            quiet_phase;
    int            sink_hold;
    int            err_count;
    int            results_checked;
    int            fired_total;
    int            n_ticks;
    int            n_adds;
    int            n_removes;

    job_timer_table_core #(
        .MAX_JOBS(JOBS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (req),
        .o_res_valid(o_res_valid),
        .i_res_ready(res_ready),
        .o_res      (o_res)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (err_count < 40) begin
            $display("ERROR t=%0t %s", $realtime, what);
        end
        err_count++;
    endtask

    task automatic predict_timer_request(input jtt_pkg::t_req r);
        jtt_pkg::t_res res;
        jtt_pkg::t_res batch[$];
        int            hit;
        res = '0;
        hit = -1;
        case (r.func)
            jtt_pkg::FUNC_TICK: begin
                n_ticks++;
                for (int i = 0; i < slot_count && batch.size() < jtt_pkg::RES_MAX; i++) begin
                    if (!timer_slots[i].expired && 53'(r.now_us) >= timer_slots[i].due_us) begin
                        if (timer_slots[i].fire_cnt != jtt_pkg::FIRES_MAX) begin
                            timer_slots[i].fire_cnt++;
                        end
                        if (timer_slots[i].one_shot) begin
                            timer_slots[i].expired = 1'b1;
                        end else begin
                            timer_slots[i].due_us = 53'(r.now_us)
                                + 53'(timer_slots[i].period) * 53'(jtt_pkg::US_PER_S);
                        end
                        res.kind         = jtt_pkg::KIND_FIRED;
                        res.status       = jtt_pkg::STAT_OK;
                        res.entry_id     = timer_slots[i].tag;
                        res.slot         = 4'(i);
                        res.fires        = timer_slots[i].fire_cnt;
                        res.was_one_shot = timer_slots[i].one_shot;
                        batch.push_back(res);
                        fired_total++;
                    end
                end
            end
            jtt_pkg::FUNC_ADD: begin
                n_adds++;
                res.kind = jtt_pkg::KIND_ADD_ACK;
                if (slot_count >= JOBS) begin
                    res.status = jtt_pkg::STAT_FULL;
                end else if (!r.job_kind && r.period_s == '0) begin
                    res.status = jtt_pkg::STAT_BAD_IVAL;
                end else begin
                    timer_slots[slot_count].tag      = r.now_us[31:0];
                    timer_slots[slot_count].one_shot = r.job_kind;
                    timer_slots[slot_count].expired  = 1'b0;
                    timer_slots[slot_count].period   = r.job_kind ? 20'd0 : r.period_s;
                    timer_slots[slot_count].due_us   = r.job_kind
                        ? 53'(r.at_epoch_s) * 53'(jtt_pkg::US_PER_S)
                        : 53'(r.now_us) + 53'(r.period_s) * 53'(jtt_pkg::US_PER_S);
                    timer_slots[slot_count].fire_cnt = '0;
                    res.status   = jtt_pkg::STAT_OK;
                    res.entry_id = r.now_us[31:0];
                    res.slot     = 4'(slot_count);
                    slot_count++;
                end
                batch.push_back(res);
            end
            jtt_pkg::FUNC_REMOVE: begin
                n_removes++;
                res.kind     = jtt_pkg::KIND_RM_ACK;
                res.entry_id = r.remove_id;
                for (int i = 0; i < slot_count && hit < 0; i++) begin
                    if (timer_slots[i].tag == r.remove_id) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    res.status = jtt_pkg::STAT_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < slot_count; i++) begin
                        timer_slots[i] = timer_slots[i + 1];
                    end
                    slot_count--;
                    res.status = jtt_pkg::STAT_OK;
                    res.slot   = 4'(hit);
                end
                batch.push_back(res);
            end
            default: ;
        endcase
        if (batch.size() != 0) begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k]) begin
                pending_results.push_back(batch[k]);
            end
        end
    endtask

    task automatic check_result(input jtt_pkg::t_res got);
        jtt_pkg::t_res want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind=%0d id=%h slot=%0d",
                                    got.kind, got.entry_id, got.slot));
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.kind !== want.kind)
            flag_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
        if (got.status !== want.status)
            flag_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.entry_id !== want.entry_id)
            flag_mismatch($sformatf("entry_id got %h want %h", got.entry_id, want.entry_id));
        if (got.slot !== want.slot)
            flag_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
        if (got.fires !== want.fires)
            flag_mismatch($sformatf("fires got %0d want %0d", got.fires, want.fires));
        if (got.was_one_shot !== want.was_one_shot)
            flag_mismatch($sformatf("was_one_shot got %b want %b",
                                    got.was_one_shot, want.was_one_shot));
        if (got.last !== want.last)
            flag_mismatch($sformatf("last got %b want %b", got.last, want.last));
    endtask

    always @(posedge clk) begin
        if (rst_n && o_res_valid && res_ready) begin
            check_result(o_res);
        end
    end

    always @(posedge clk) begin
        if (o_res_valid && res_ready) begin
            sink_hold = quiet_phase ? 0 : $urandom_range(0, 17);
            if (sink_hold != 0) begin
                res_ready <= 1'b0;
            end
        end else if (!res_ready) begin
            if (sink_hold <= 0) begin
                res_ready <= 1'b1;
            end else begin
                sink_hold--;
            end
        end
    end

    task automatic send_request(input jtt_pkg::t_req r);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!(req_valid && o_req_ready));
        predict_timer_request(r);
    endtask

    function automatic jtt_pkg::t_req make_req(input logic [1:0] func,
                                               input logic [51:0] now,
                                               input logic kind, input logic [19:0] ival,
                                               input logic [31:0] epoch,
                                               input logic [31:0] rid);
        jtt_pkg::t_req r;
        r.func       = func;
        r.now_us     = now;
        r.job_kind   = kind;
        r.period_s   = ival;
        r.at_epoch_s = epoch;
        r.remove_id  = rid;
        return r;
    endfunction

    function automatic jtt_pkg::t_req random_req();
        jtt_pkg::t_req r;
        r.func       = 2'($urandom_range(0, 3));
        r.now_us     = {20'($urandom), $urandom};
        r.job_kind   = 1'($urandom);
        r.period_s   = 20'($urandom);
        r.at_epoch_s = $urandom;
        r.remove_id  = $urandom;
        return r;
    endfunction

    task automatic test_edge_cases();
        send_request(make_req(jtt_pkg::FUNC_TICK, 52'd0, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(FUNC_UNUSED, '1, 1'b1, '1, '1, '1));
        send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0,
                              32'hFFFF_FFFF));
        send_request(make_req(jtt_pkg::FUNC_ADD, 52'h123, 1'b0, 20'd0, '1, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_ADD, 52'd0, 1'b0, 20'd1, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_ADD, 52'h5, 1'b1, '1, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_ADD, 52'h7, 1'b1, 20'd0, '1, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_ADD, '1, 1'b0, '1, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_ADD, 52'h1_0000_0000, 1'b0, '1, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_TICK, 52'd1_000_000, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_TICK, 52'd1_000_000, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_TICK, 52'd2_000_000, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0,
                              32'hFFFF_FFFF));
        send_request(make_req(jtt_pkg::FUNC_TICK, '1, 1'b0, 20'd0, 32'd0, 32'd0));
    endtask

    task automatic test_table_full();
        while (slot_count > 0) begin
            send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0,
                                  timer_slots[0].tag));
        end
        for (int k = 0; k < JOBS; k++) begin
            send_request(make_req(jtt_pkg::FUNC_ADD, sim_now + 52'(k), 1'b0,
                                  20'($urandom_range(1, 3)), $urandom, 32'd0));
        end
        send_request(make_req(jtt_pkg::FUNC_ADD, sim_now, 1'b0, 20'd5, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_ADD, sim_now, 1'b0, 20'd0, 32'd0, 32'd0));
        sim_now = sim_now + 52'd10_000_000;
        send_request(make_req(jtt_pkg::FUNC_TICK, sim_now, 1'b0, 20'd0, 32'd0, 32'd0));
        send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0,
                              timer_slots[JOBS - 1].tag));
        send_request(make_req(jtt_pkg::FUNC_REMOVE, 52'd0, 1'b0, 20'd0, 32'd0,
                              timer_slots[7].tag));
    endtask

    task automatic test_random_traffic(input int n_items);
        jtt_pkg::t_req r;
        int            pick;
        int            sent;
        logic [51:0]   epoch_base;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 40 == 0) begin
                quiet_phase = ($urandom_range(0, 3) == 0);
            end
            r    = random_req();
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
            end else if (pick < 47) begin
                r.func   = jtt_pkg::FUNC_TICK;
                sim_now  = sim_now + 52'($urandom_range(0, 3_000_000));
                r.now_us = sim_now;
            end else if (pick < 75) begin
                r.func = jtt_pkg::FUNC_ADD;
                if ($urandom_range(0, 9) == 0) begin
                    r.now_us = last_add_now;
                end else begin
                    r.now_us = sim_now + 52'($urandom_range(0, 999_999));
                end
                last_add_now = r.now_us;
                r.job_kind   = ($urandom_range(0, 2) == 0);
                r.period_s   = ($urandom_range(0, 19) == 0) ? 20'd0
                                                            : 20'($urandom_range(1, 6));
                epoch_base   = sim_now / 52'd1_000_000;
                r.at_epoch_s = epoch_base[31:0] + $urandom_range(0, 8) - 32'd3;
            end else begin
                r.func = jtt_pkg::FUNC_REMOVE;
                if (slot_count > 0 && $urandom_range(0, 4) != 0) begin
                    r.remove_id = timer_slots[$urandom_range(0, slot_count - 1)].tag;
                end
            end
            send_request(r);
            if (r.func != FUNC_UNUSED) begin
                sent++;
            end
        end
    endtask

    initial begin
        #(3_000_000);
        $display("FAIL job_timer_table_core");
        $finish;
    end

    initial begin
        sim_now      = {20'($urandom_range(0, 900_000)), $urandom};
        last_add_now = sim_now;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_cases();
        test_table_full();
        test_random_traffic(230);
        req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        $display("Run covered %0d ticks, %0d adds and %0d removes;", n_ticks, n_adds, n_removes);
        $display("%0d results checked, %0d of them firings, %0d mismatches.",
                 results_checked, fired_total, err_count);
        if (err_count == 0) begin
            $display("PASS job_timer_table_core");
        end else begin
            $display("FAIL job_timer_table_core");
        end
        $finish;
    end
endmodule

[files.f]
rtl/core/jtt_pkg.sv
rtl/core/jtt_ram.sv
rtl/core/jtt_dp.sv
rtl/core/jtt_ctrl.sv
rtl/core/job_timer_table_core.sv
dv/job_timer_table_core_tb.sv
